>>> rtl/tcon_pkg.sv
// ----------------------------------------------------------------------------
// tcon_pkg
// Shared types and constants for the text console character engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcon_pkg;

  // Screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int FIRST_ROW = 1;
  localparam int CELLS     = ROWS * COLUMNS;

  // Memory index and sweep pointer widths (pointer can hold CELLS itself)
  localparam int IDX_W = $clog2(CELLS);
  localparam int PTR_W = $clog2(CELLS + 1);

  // Field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int OFF_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // Commands
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Byte codes
  localparam logic [CHAR_W-1:0] CH_BS       = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF       = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd126;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK = 2'd2;
  localparam int CFG_DATA_W = 4;

  localparam logic [3:0] FORE_RESET = 4'd15;

  typedef struct packed {
    logic              cmd;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [OFF_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_value;
  } out_t;

  // Screen memory request: one write and one read per cycle
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [CELL_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/tcon_screen_ram.sv
// ----------------------------------------------------------------------------
// tcon_screen_ram
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcon_screen_ram (
  input  wire logic                        clk,
  input  wire tcon_pkg::mem_req_t          req,
  output logic [tcon_pkg::CELL_W-1:0]      rdata
);

  logic [tcon_pkg::CELL_W-1:0] mem [tcon_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

>>> rtl/tcon_ctrl.sv
// ----------------------------------------------------------------------------
// tcon_ctrl
// Cursor state, item sequencer and the shared sweep pointer that drives
// clear and scroll copy through the screen memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcon_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [tcon_pkg::ATTR_W-1:0]   attr,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire tcon_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tcon_pkg::out_t                     out_data,
  output tcon_pkg::mem_req_t                 mem_req,
  input  wire logic [tcon_pkg::CELL_W-1:0]   mem_rdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_CLEAR  = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  localparam int PTR_W = tcon_pkg::PTR_W;
  localparam int IDX_W = tcon_pkg::IDX_W;
  localparam int ROW_W = tcon_pkg::ROW_W;
  localparam int COL_W = tcon_pkg::COL_W;

  logic [2:0]                  state_r, state_nxt;
  logic [PTR_W-1:0]            ptr_r, ptr_nxt;
  logic [IDX_W-1:0]            wptr_r, wptr_nxt;
  logic                        pend_r, pend_nxt;
  logic                        resp_pend_r, resp_pend_nxt;
  logic [ROW_W-1:0]            row_r, row_nxt;
  logic [COL_W-1:0]            col_r, col_nxt;
  logic [tcon_pkg::CELL_W-1:0] cell_r, cell_nxt;
  logic                        out_valid_r, out_valid_nxt;
  tcon_pkg::out_t              out_r, out_nxt;

  logic [PTR_W-1:0] cur_off;
  logic [PTR_W-1:0] rd_off;
  logic [COL_W:0]   tab_col;
  logic             rd_in_range;
  logic             line_feed;
  logic             out_take;

  assign cur_off = PTR_W'(row_r) * PTR_W'(tcon_pkg::COLUMNS) + PTR_W'(col_r);
  assign rd_off  = PTR_W'(in_data.read_row) * PTR_W'(tcon_pkg::COLUMNS)
                 + PTR_W'(in_data.read_col);
  assign tab_col = ({1'b0, col_r} | (COL_W+1)'(7)) + (COL_W+1)'(1);
  assign rd_in_range = (in_data.read_row < ROW_W'(tcon_pkg::ROWS)) &&
                       (in_data.read_col < COL_W'(tcon_pkg::COLUMNS));
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    wptr_nxt      = wptr_r;
    pend_nxt      = pend_r;
    resp_pend_nxt = resp_pend_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cell_nxt      = cell_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    line_feed     = 1'b0;

    mem_req.we    = 1'b0;
    mem_req.waddr = wptr_r;
    mem_req.wdata = tcon_pkg::BLANK_CELL;
    mem_req.raddr = ptr_r[IDX_W-1:0];

    in_stall = (state_r != S_IDLE);

    if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cell_nxt  = '0;
          state_nxt = S_RESP;
          if (in_data.cmd == tcon_pkg::CMD_READ) begin
            if (rd_in_range) begin
              mem_req.raddr = rd_off[IDX_W-1:0];
              state_nxt     = S_READ;
            end
          end else if (in_data.char_code inside
                       {[tcon_pkg::CH_PRINT_LO:tcon_pkg::CH_PRINT_HI]}) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = cur_off[IDX_W-1:0];
            mem_req.wdata = {attr, in_data.char_code};
            if (col_r == COL_W'(tcon_pkg::COLUMNS - 1)) begin
              col_nxt   = '0;
              line_feed = 1'b1;
            end else begin
              col_nxt = col_r + COL_W'(1);
            end
          end else begin
            case (in_data.char_code)
              tcon_pkg::CH_BS: begin
                if (col_r != '0) begin
                  col_nxt = col_r - COL_W'(1);
                end
              end
              tcon_pkg::CH_TAB: begin
                if (tab_col >= (COL_W+1)'(tcon_pkg::COLUMNS)) begin
                  col_nxt = COL_W'(tcon_pkg::COLUMNS - 1);
                end else begin
                  col_nxt = tab_col[COL_W-1:0];
                end
              end
              tcon_pkg::CH_LF: begin
                col_nxt   = '0;
                line_feed = 1'b1;
              end
              tcon_pkg::CH_FF: begin
                row_nxt       = ROW_W'(tcon_pkg::FIRST_ROW);
                col_nxt       = '0;
                ptr_nxt       = '0;
                resp_pend_nxt = 1'b1;
                state_nxt     = S_CLEAR;
              end
              tcon_pkg::CH_CR: begin
                col_nxt = '0;
              end
              default: ;
            endcase
          end

          if (line_feed) begin
            if (row_r < ROW_W'(tcon_pkg::ROWS - 1)) begin
              row_nxt = row_r + ROW_W'(1);
            end else begin
              // last row: scroll, cursor row stays put
              ptr_nxt   = PTR_W'((tcon_pkg::FIRST_ROW + 1) * tcon_pkg::COLUMNS);
              pend_nxt  = 1'b0;
              state_nxt = S_SCROLL;
            end
          end
        end
      end

      S_READ: begin
        cell_nxt  = mem_rdata;
        state_nxt = S_RESP;
      end

      S_SCROLL: begin
        // write the cell read last cycle one row up, read the next
        mem_req.we    = pend_r;
        mem_req.waddr = wptr_r;
        mem_req.wdata = mem_rdata;
        if (ptr_r < PTR_W'(tcon_pkg::CELLS)) begin
          pend_nxt = 1'b1;
          wptr_nxt = IDX_W'(ptr_r - PTR_W'(tcon_pkg::COLUMNS));
          ptr_nxt  = ptr_r + PTR_W'(1);
        end else begin
          pend_nxt      = 1'b0;
          ptr_nxt       = PTR_W'((tcon_pkg::ROWS - 1) * tcon_pkg::COLUMNS);
          resp_pend_nxt = 1'b1;
          state_nxt     = S_CLEAR;
        end
      end

      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r[IDX_W-1:0];
        mem_req.wdata = tcon_pkg::BLANK_CELL;
        if (ptr_r == PTR_W'(tcon_pkg::CELLS - 1)) begin
          state_nxt = resp_pend_r ? S_RESP : S_IDLE;
        end else begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
      end

      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || out_take) begin
          out_valid_nxt         = 1'b1;
          out_nxt.cursor_row    = row_r;
          out_nxt.cursor_col    = col_r;
          out_nxt.cursor_offset = tcon_pkg::OFF_W'(cur_off);
          out_nxt.cell_value    = cell_r;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      resp_pend_r <= 1'b0;
      row_r       <= ROW_W'(tcon_pkg::FIRST_ROW);
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      resp_pend_r <= resp_pend_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wptr_r <= wptr_nxt;
    cell_r <= cell_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> rtl/text_console_char_engine.sv
// ----------------------------------------------------------------------------
// text_console_char_engine
// Text-mode console: cursor handling, screen store, scrolling and readback.
// ----------------------------------------------------------------------------
// Each beat on the input either processes one byte or reads one screen cell
// and returns exactly one result beat with the cursor after the item. Cell
// reads pass through a read state before the result state, ordinary bytes
// go straight to it; a form feed sweeps the whole screen memory one cell a
// cycle, and a scroll copies one cell a cycle through the single write port
// plus a blanking sweep of the last row. After reset the block runs a
// clearing pass over the whole screen before the first beat is accepted;
// configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_engine (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [tcon_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tcon_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire tcon_pkg::in_t                    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output tcon_pkg::out_t                        out_data
);

  logic [3:0]                  fore_r;
  logic [2:0]                  back_r;
  logic                        blink_r;
  logic [tcon_pkg::ATTR_W-1:0] attr;
  tcon_pkg::mem_req_t          mem_req;
  logic [tcon_pkg::CELL_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r  <= tcon_pkg::FORE_RESET;
      back_r  <= '0;
      blink_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tcon_pkg::CFG_FORE:  fore_r  <= cfg_wdata[3:0];
        tcon_pkg::CFG_BACK:  back_r  <= cfg_wdata[2:0];
        tcon_pkg::CFG_BLINK: blink_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign attr = {blink_r, back_r, fore_r};

  tcon_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      (attr),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  tcon_screen_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> rtl/tcon_checker.sv
// ----------------------------------------------------------------------------
// tcon_checker
// Port-level checks for the text console character engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcon_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire tcon_pkg::out_t out_data
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // Every accepted item leaves the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on back-to-back cycles");

  // Cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cursor_row < tcon_pkg::ROW_W'(tcon_pkg::ROWS)) &&
                  (out_data.cursor_col < tcon_pkg::COL_W'(tcon_pkg::COLUMNS)))
    else $error("cursor off screen");

  // Offset agrees with row and column
  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cursor_offset ==
      tcon_pkg::OFF_W'(tcon_pkg::OFF_W'(out_data.cursor_row) *
                       tcon_pkg::OFF_W'(tcon_pkg::COLUMNS) +
                       tcon_pkg::OFF_W'(out_data.cursor_col)))
    else $error("cursor offset mismatch");

endmodule

bind text_console_char_engine tcon_checker u_tcon_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

>>> test/tb_text_console_char_engine.sv
// ----------------------------------------------------------------------------
// tb_text_console_char_engine
// Self-checking bench for the text console character engine. A mirror of
// the screen, cursor and color registers predicts one result beat per
// input beat. Results are compared field by field in order. Stimulus is a
// short directed run, then sessions of random text with control codes,
// cell reads, scrolls and clears, under several color settings and
// random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_char_engine;

  localparam int CLK_HALF_NS   = 6;
  localparam int LIMIT_NS      = 200_000_000;
  localparam int DRAIN_CYCLES  = 2100;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 11;
  localparam int SESSION_ITEMS = 118;

  localparam int COLUMNS   = tcon_pkg::COLUMNS;
  localparam int ROWS      = tcon_pkg::ROWS;
  localparam int FIRST_ROW = tcon_pkg::FIRST_ROW;
  localparam int CELLS     = tcon_pkg::CELLS;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [tcon_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tcon_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  tcon_pkg::in_t                   in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  tcon_pkg::out_t                  out_data;

  text_console_char_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Mirror of the console state
  logic [tcon_pkg::CELL_W-1:0] screen_mem [CELLS];
  int unsigned                 cur_row;
  int unsigned                 cur_col;
  logic [3:0]                  fore_reg;
  logic [2:0]                  back_reg;
  logic                        blink_reg;

  tcon_pkg::in_t  console_items [$];
  tcon_pkg::out_t cursor_reports [$];

  int unsigned in_idle_max   = 0;
  int unsigned out_idle_max  = 0;
  int unsigned in_gap        = 0;
  int unsigned out_wait      = 0;
  int unsigned hold_left     = 0;
  int unsigned pushed_count  = 0;
  int unsigned results_seen  = 0;
  bit          in_taken      = 1'b0;
  bit          out_taken     = 1'b0;
  bit          pressure_go   = 1'b0;
  bit          pressure_seen = 1'b0;
  bit          failed        = 1'b0;

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen_mem[i] = tcon_pkg::BLANK_CELL;
  endfunction

  function automatic void advance_line();
    if (cur_row + 1 < ROWS) begin
      cur_row++;
    end else begin
      // shift the scrolling region up, rows above FIRST_ROW stay
      for (int i = FIRST_ROW * COLUMNS; i < (ROWS - 1) * COLUMNS; i++)
        screen_mem[i] = screen_mem[i + COLUMNS];
      for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
        screen_mem[i] = tcon_pkg::BLANK_CELL;
    end
  endfunction

  function automatic tcon_pkg::out_t console_apply(tcon_pkg::in_t item);
    tcon_pkg::out_t res;
    int unsigned tab_col;
    res = '0;
    if (item.cmd == tcon_pkg::CMD_CHAR) begin
      if (item.char_code >= tcon_pkg::CH_PRINT_LO &&
          item.char_code <= tcon_pkg::CH_PRINT_HI) begin
        screen_mem[cur_row * COLUMNS + cur_col] =
          {blink_reg, back_reg, fore_reg, item.char_code};
        cur_col++;
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          advance_line();
        end
      end else begin
        case (item.char_code)
          tcon_pkg::CH_BS: begin
            if (cur_col != 0) cur_col--;
          end
          tcon_pkg::CH_TAB: begin
            tab_col = (cur_col | 7) + 1;
            cur_col = (tab_col >= COLUMNS) ? COLUMNS - 1 : tab_col;
          end
          tcon_pkg::CH_LF: begin
            advance_line();
            cur_col = 0;
          end
          tcon_pkg::CH_FF: begin
            blank_screen();
            cur_row = FIRST_ROW;
            cur_col = 0;
          end
          tcon_pkg::CH_CR: cur_col = 0;
          default: ;
        endcase
      end
    end else if (item.read_row < ROWS && item.read_col < COLUMNS) begin
      res.cell_value = screen_mem[item.read_row * COLUMNS + item.read_col];
    end
    res.cursor_row    = tcon_pkg::ROW_W'(cur_row);
    res.cursor_col    = tcon_pkg::COL_W'(cur_col);
    res.cursor_offset = tcon_pkg::OFF_W'(cur_col + cur_row * COLUMNS);
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  task automatic push_char(input int code);
    tcon_pkg::in_t item;
    item.cmd       = tcon_pkg::CMD_CHAR;
    item.char_code = tcon_pkg::CHAR_W'(code);
    item.read_row  = tcon_pkg::ROW_W'($urandom);
    item.read_col  = tcon_pkg::COL_W'($urandom);
    console_items.push_back(item);
    pushed_count++;
  endtask

  task automatic push_read(input int row, input int col);
    tcon_pkg::in_t item;
    item.cmd       = tcon_pkg::CMD_READ;
    item.char_code = tcon_pkg::CHAR_W'($urandom);
    item.read_row  = tcon_pkg::ROW_W'(row);
    item.read_col  = tcon_pkg::COL_W'(col);
    console_items.push_back(item);
    pushed_count++;
  endtask

  task automatic push_session(input int count, input int lf_pct);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        if ($urandom_range(0, 7) == 0)
          push_read($urandom_range(0, 31), $urandom_range(0, 127));
        else
          push_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
      end else if (pick < 12 + lf_pct) push_char(tcon_pkg::CH_LF);
      else if (pick < 13 + lf_pct) push_char(tcon_pkg::CH_FF);
      else if (pick < 16 + lf_pct) push_char(tcon_pkg::CH_BS);
      else if (pick < 19 + lf_pct) push_char(tcon_pkg::CH_TAB);
      else if (pick < 21 + lf_pct) push_char(tcon_pkg::CH_CR);
      else if (pick < 24 + lf_pct) push_char($urandom_range(0, 255));
      else push_char($urandom_range(tcon_pkg::CH_PRINT_LO, tcon_pkg::CH_PRINT_HI));
    end
  endtask

  task automatic write_colors(input int fore, input int back, input int blink);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tcon_pkg::CFG_FORE;
    cfg_wdata <= tcon_pkg::CFG_DATA_W'(fore);
    @(negedge clk);
    cfg_index <= tcon_pkg::CFG_BACK;
    cfg_wdata <= tcon_pkg::CFG_DATA_W'(back);
    @(negedge clk);
    cfg_index <= tcon_pkg::CFG_BLINK;
    cfg_wdata <= tcon_pkg::CFG_DATA_W'(blink);
    @(negedge clk);
    cfg_we    <= 1'b0;
    fore_reg  = 4'(fore);
    back_reg  = 3'(back);
    blink_reg = 1'(blink);
  endtask

  task automatic wait_drained();
    while (results_seen != pushed_count) @(negedge clk);
  endtask

  // Sender: offer the next item after its drawn gap, hold while stalled
  always @(negedge clk) begin : item_feed
    logic          next_valid;
    tcon_pkg::in_t next_item;
    next_valid = in_valid;
    next_item  = in_data;
    if (rst_n && (!in_valid || in_taken)) begin
      next_valid = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
      end else if (console_items.size() != 0) begin
        next_item  = console_items.pop_front();
        next_valid = 1'b1;
        in_gap     = $urandom_range(0, in_idle_max);
      end
    end
    in_valid <= next_valid;
    in_data  <= next_item;
  end

  // Receiver: stall each result beat a drawn number of cycles
  always @(negedge clk) begin : result_pace
    if (pressure_go != pressure_seen) begin
      pressure_seen = pressure_go;
      hold_left     = HOLD_CYCLES;
    end
    if (out_taken) out_wait = $urandom_range(0, out_idle_max);
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (out_wait != 0) begin
      if (out_valid) out_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check result beats first, then predict from the input beat of this edge
  always @(posedge clk) begin : beat_check
    tcon_pkg::out_t want;
    out_taken = rst_n && out_valid && !out_stall;
    in_taken  = rst_n && in_valid && !in_stall;
    if (out_taken) begin
      if (cursor_reports.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %h", $time, out_data);
        failed = 1'b1;
      end else begin
        want = cursor_reports.pop_front();
        results_seen++;
        check_field("cursor_row", want.cursor_row, out_data.cursor_row);
        check_field("cursor_col", want.cursor_col, out_data.cursor_col);
        check_field("cursor_offset", want.cursor_offset, out_data.cursor_offset);
        check_field("cell_value", want.cell_value, out_data.cell_value);
      end
    end
    if (in_taken) cursor_reports.push_back(console_apply(in_data));
  end

  initial begin
    blank_screen();
    cur_row   = FIRST_ROW;
    cur_col   = 0;
    fore_reg  = tcon_pkg::FORE_RESET;
    back_reg  = '0;
    blink_reg = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, out-of-range reads, printable edges, noise,
    // backspace at column 0, tab stops up to the last column, wrap, clear
    push_read(FIRST_ROW, 0);
    push_read(31, 127);
    push_read(ROWS, 0);
    push_read(0, COLUMNS);
    push_char(tcon_pkg::CH_PRINT_LO);
    push_char(tcon_pkg::CH_PRINT_HI);
    push_char(tcon_pkg::CH_PRINT_LO - 1);
    push_char(tcon_pkg::CH_PRINT_HI + 1);
    push_char(255);
    push_char(0);
    push_read(FIRST_ROW, 1);
    repeat (3) push_char(tcon_pkg::CH_BS);
    push_char(tcon_pkg::CH_CR);
    repeat (11) push_char(tcon_pkg::CH_TAB);
    push_char(65);
    push_char(tcon_pkg::CH_LF);
    push_char(tcon_pkg::CH_FF);
    push_read(FIRST_ROW, 0);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       write_colors(0, 0, 0);
        1:       write_colors(15, 7, 1);
        default: write_colors($urandom_range(0, 15), $urandom_range(0, 7),
                              $urandom_range(0, 1));
      endcase
      if (ph % 3 == 0) begin
        in_idle_max  = 0;
        out_idle_max = 0;
      end else if (ph == 1) begin
        in_idle_max  = 8;
        out_idle_max = 8;
      end else begin
        in_idle_max  = 8 * $urandom_range(0, 1);
        out_idle_max = 8 * $urandom_range(0, 1);
      end
      // hold off results while the sender keeps offering
      if (ph == 3) pressure_go = !pressure_go;
      if (ph % 4 == 2) begin
        // walk down to the last row, then wrap and scroll
        push_char(tcon_pkg::CH_FF);
        repeat (ROWS - 1 - FIRST_ROW) push_char(tcon_pkg::CH_LF);
        repeat (COLUMNS)
          push_char($urandom_range(tcon_pkg::CH_PRINT_LO, tcon_pkg::CH_PRINT_HI));
        push_read(ROWS - 2, $urandom_range(0, COLUMNS - 1));
        push_read(0, $urandom_range(0, COLUMNS - 1));
        push_session(SESSION_ITEMS, 10);
      end else begin
        push_session(SESSION_ITEMS, 6);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (!failed && cursor_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #LIMIT_NS;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
